>>> rtl/core/iojoin_pkg.sv
package iojoin_pkg;

    localparam int EXON_DEPTH  = 64;
    localparam int CHROM_COUNT = 24;
    localparam int IDX_W       = (EXON_DEPTH > 1) ? $clog2(EXON_DEPTH) : 1;
    localparam int CNT_W       = $clog2(EXON_DEPTH + 1);
    localparam int CHR_W       = 5;
    localparam int POS_W       = 31;
    localparam int VAL_W       = 16;
    localparam int FRAC_W      = 17;
    localparam int XIDX_W      = 6;
    localparam int CASE_W      = 2;
    localparam int OP_W        = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int DIV_STEPS   = 17;
    localparam int STEP_W      = 5;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 40;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CASE_W-1:0] CASE_COVERED = 2'd0;
    localparam logic [CASE_W-1:0] CASE_ENDS_IN = 2'd1;
    localparam logic [CASE_W-1:0] CASE_INSIDE  = 2'd2;
    localparam logic [CASE_W-1:0] CASE_STARTS  = 2'd3;

    // One match found by the scan, waiting for its fraction.
    typedef struct packed {
        logic              matched;
        logic [XIDX_W-1:0] exon_index;
        logic [CASE_W-1:0] overlap_case;
        logic [POS_W-1:0]  num;
        logic [POS_W-1:0]  den;
        logic [VAL_W-1:0]  value;
        logic              last;
    } match_rec_t;

endpackage

>>> rtl/core/iojoin_queue.sv
module iojoin_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  iojoin_pkg::match_rec_t push_rec,
    input  logic                   pop,
    output iojoin_pkg::match_rec_t head_rec,
    output logic                   full,
    output logic                   almost_full,
    output logic                   empty
);
    import iojoin_pkg::*;

    match_rec_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full        = (count_reg == QCNT_W'(QDEPTH));
    assign almost_full = (count_reg >= QCNT_W'(QDEPTH - 1));
    assign empty       = (count_reg == '0);
    assign head_rec    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // A push into a full queue would overwrite a match not yet handled.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue pop while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

>>> rtl/core/iojoin_front.sv
module iojoin_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [iojoin_pkg::OP_W-1:0]  operation,
    input  logic [iojoin_pkg::CHR_W-1:0] chromosome,
    input  logic [iojoin_pkg::POS_W-1:0] start_pos,
    input  logic [iojoin_pkg::POS_W-1:0] end_pos,
    input  logic [iojoin_pkg::POS_W-1:0] next_end,
    input  logic [iojoin_pkg::VAL_W-1:0] copy_value,
    input  logic                      q_full,
    input  logic                      q_almost_full,
    output logic                      q_push,
    output iojoin_pkg::match_rec_t    q_rec
);
    import iojoin_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } front_state_t;

    front_state_t       state_reg, state_next;

    logic [CHR_W-1:0]   chrom_mem [EXON_DEPTH];
    logic [POS_W-1:0]   start_mem [EXON_DEPTH];
    logic [POS_W-1:0]   end_mem   [EXON_DEPTH];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   rd_addr_reg;
    logic               dv_reg;
    logic [IDX_W-1:0]   didx_reg;
    logic [CHR_W-1:0]   dchr_reg;
    logic [POS_W-1:0]   des_reg;
    logic [POS_W-1:0]   dee_reg;

    logic [CHR_W-1:0]   q_chr_reg;
    logic [POS_W-1:0]   q_rs_reg;
    logic [POS_W-1:0]   q_re_reg;
    logic [POS_W-1:0]   q_ne_reg;
    logic [VAL_W-1:0]   q_val_reg;

    logic               pend_v_reg;
    match_rec_t         pend_reg;

    logic               accept;
    logic               do_load;
    logic               issue;
    logic               hit;
    match_rec_t         cur_rec;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign do_load  = accept && (operation == OP_LOAD)
                      && (chromosome < CHR_W'(CHROM_COUNT))
                      && (count_reg < CNT_W'(EXON_DEPTH));
    assign issue    = (state_reg == ST_SCAN) && (rd_addr_reg < count_reg)
                      && !q_almost_full;

    // Overlap classification of the exon in the read stage.
    always_comb
    begin
        hit                  = 1'b0;
        cur_rec              = '0;
        cur_rec.matched      = 1'b1;
        cur_rec.exon_index   = XIDX_W'(didx_reg);
        cur_rec.value        = q_val_reg;
        cur_rec.den          = dee_reg - des_reg;
        if (dv_reg && (dchr_reg == q_chr_reg))
        begin
            if ((des_reg >= q_rs_reg) && (dee_reg <= q_re_reg))
            begin
                hit                  = 1'b1;
                cur_rec.overlap_case = CASE_COVERED;
            end
            else if ((des_reg >= q_rs_reg) && (des_reg < q_re_reg)
                     && (dee_reg < q_ne_reg))
            begin
                hit                  = 1'b1;
                cur_rec.overlap_case = CASE_ENDS_IN;
                cur_rec.num          = q_re_reg - des_reg;
            end
            else if ((des_reg < q_rs_reg) && (dee_reg > q_re_reg))
            begin
                hit                  = 1'b1;
                cur_rec.overlap_case = CASE_INSIDE;
                cur_rec.num          = (q_re_reg > q_rs_reg) ? (q_re_reg - q_rs_reg) : '0;
            end
            else if ((des_reg < q_rs_reg) && (dee_reg <= q_re_reg)
                     && (dee_reg > q_rs_reg))
            begin
                hit                  = 1'b1;
                cur_rec.overlap_case = CASE_STARTS;
                cur_rec.num          = dee_reg - q_rs_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        q_rec      = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit && pend_v_reg)
                begin
                    q_push = 1'b1;
                end
                if (!dv_reg && !issue && (rd_addr_reg >= count_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    if (pend_v_reg)
                    begin
                        q_rec.last = 1'b1;
                    end
                    else
                    begin
                        q_rec       = '0;
                        q_rec.value = q_val_reg;
                        q_rec.last  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_addr_reg <= '0;
            dv_reg      <= 1'b0;
            pend_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= issue;
            if (do_load)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (accept && (operation == OP_CLEAR))
            begin
                count_reg <= '0;
            end
            if (accept && (operation == OP_QUERY))
            begin
                rd_addr_reg <= '0;
                pend_v_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
                if (hit)
                begin
                    pend_v_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            chrom_mem[count_reg[IDX_W-1:0]] <= chromosome;
            start_mem[count_reg[IDX_W-1:0]] <= start_pos;
            end_mem[count_reg[IDX_W-1:0]]   <= end_pos;
        end
        dchr_reg <= chrom_mem[rd_addr_reg[IDX_W-1:0]];
        des_reg  <= start_mem[rd_addr_reg[IDX_W-1:0]];
        dee_reg  <= end_mem[rd_addr_reg[IDX_W-1:0]];
        didx_reg <= rd_addr_reg[IDX_W-1:0];
        if (accept && (operation == OP_QUERY))
        begin
            q_chr_reg <= chromosome;
            q_rs_reg  <= start_pos;
            q_re_reg  <= end_pos;
            q_ne_reg  <= next_end;
            q_val_reg <= copy_value;
        end
        if (hit)
        begin
            pend_reg <= cur_rec;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(EXON_DEPTH))
        else $error("exon count beyond table depth");

    a_no_issue_past_count: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (rd_addr_reg < count_reg))
        else $error("scan read beyond stored exons");

    a_finish_pushes_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !q_full) |-> (q_push && q_rec.last))
        else $error("query closed without a final result");

endmodule

>>> rtl/core/iojoin_back.sv
module iojoin_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iojoin_pkg::match_rec_t       head_rec,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_matched,
    output logic [iojoin_pkg::XIDX_W-1:0] out_index,
    output logic [iojoin_pkg::CASE_W-1:0] out_case,
    output logic [iojoin_pkg::FRAC_W-1:0] out_frac,
    output logic [iojoin_pkg::VAL_W-1:0]  out_value,
    output logic                         out_last
);
    import iojoin_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [POS_W:0]     rem_reg;
    logic [POS_W-1:0]   den_reg;
    logic [FRAC_W-1:0]  quo_reg;
    match_rec_t         rec_reg;

    logic               out_v_reg;
    logic               out_free;
    logic               needs_div;
    logic               load_direct;
    logic               load_div;
    logic [POS_W:0]     trial;
    logic               qbit;
    logic [FRAC_W-1:0]  direct_frac;

    assign out_free    = !out_v_reg || out_ready;
    assign needs_div   = head_rec.matched && (head_rec.overlap_case != CASE_COVERED)
                         && (head_rec.num != '0);
    assign direct_frac = (head_rec.matched && (head_rec.overlap_case == CASE_COVERED))
                         ? FRAC_ONE : '0;
    assign load_direct = (state_reg == BK_IDLE) && !q_empty && !needs_div && out_free;
    assign load_div    = (state_reg == BK_IDLE) && !q_empty && needs_div;
    assign q_pop       = load_direct || load_div;
    assign out_valid   = out_v_reg;

    // Restoring division, one quotient bit per cycle; the first step is unshifted.
    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[POS_W-1:0], 1'b0};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (load_div)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            out_v_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_direct || ((state_reg == BK_DONE) && out_free))
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (load_div)
            begin
                step_reg <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            rec_reg <= head_rec;
            rem_reg <= {1'b0, head_rec.num};
            den_reg <= head_rec.den;
            quo_reg <= '0;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg <= qbit ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[FRAC_W-2:0], qbit};
        end
        if (load_direct)
        begin
            out_matched <= head_rec.matched;
            out_index   <= head_rec.exon_index;
            out_case    <= head_rec.overlap_case;
            out_frac    <= direct_frac;
            out_value   <= head_rec.value;
            out_last    <= head_rec.last;
        end
        else if ((state_reg == BK_DONE) && out_free)
        begin
            out_matched <= rec_reg.matched;
            out_index   <= rec_reg.exon_index;
            out_case    <= rec_reg.overlap_case;
            out_frac    <= quo_reg;
            out_value   <= rec_reg.value;
            out_last    <= rec_reg.last;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready) |=> (out_v_reg && $stable(out_frac) && $stable(out_last)))
        else $error("result changed while stalled");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_frac <= FRAC_ONE))
        else $error("fraction above one");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE))
        else $error("queue popped while dividing");

endmodule

>>> rtl/core/interval_overlap_join.sv
// Interval overlap join of stored exons against copy-number regions.
//
// Input channel s_*: s_tuser carries the operation (load exon, query region,
// clear table). A load appends one exon; loads beyond the table
// depth or with an unknown chromosome are dropped. A clear empties the table.
// A query scans every stored exon in slot order and gives one result item per
// overlapping exon on its chromosome, or one item with matched low if none.
// Output channel m_*: m_tlast marks the final item of each query.
//
// The scan reads one exon per cycle from the exon memory while the queue
// holds fewer than three entries. Each match that needs a fraction goes
// through the shared restoring divider of the back end (the pop, 17
// quotient steps and the output load), which takes no new match until the
// last one is through.
// A four-entry queue between the scan and the divider lets each side stall
// on its own; the scan pauses once the queue holds three entries.
// Reset clears the exon count, the queue and all control state; stored
// exons beyond the count are never read. When the receiver stalls, the
// output register holds its item and backpressure reaches the input.
module interval_overlap_join (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // chromosome[4:0], start_pos[35:5], end_pos[66:36], next_end[97:67],
    // copy_value[113:98], zero fill above.
    input  logic [119:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // exon_index[5:0], coverage_fraction[22:6], region_value[38:23], zero fill above.
    output logic [39:0]  m_tdata,
    // matched[0], overlap_case[2:1]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import iojoin_pkg::*;

    match_rec_t         push_rec;
    match_rec_t         head_rec;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_almost_full;
    logic               q_empty;
    logic               out_matched;
    logic [XIDX_W-1:0]  out_index;
    logic [CASE_W-1:0]  out_case;
    logic [FRAC_W-1:0]  out_frac;
    logic [VAL_W-1:0]   out_value;

    iojoin_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .operation     (s_tuser),
        .chromosome    (s_tdata[4:0]),
        .start_pos     (s_tdata[35:5]),
        .end_pos       (s_tdata[66:36]),
        .next_end      (s_tdata[97:67]),
        .copy_value    (s_tdata[113:98]),
        .q_full        (q_full),
        .q_almost_full (q_almost_full),
        .q_push        (q_push),
        .q_rec         (push_rec)
    );

    iojoin_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_rec    (push_rec),
        .pop         (q_pop),
        .head_rec    (head_rec),
        .full        (q_full),
        .almost_full (q_almost_full),
        .empty       (q_empty)
    );

    iojoin_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_rec    (head_rec),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_matched (out_matched),
        .out_index   (out_index),
        .out_case    (out_case),
        .out_frac    (out_frac),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, out_value, out_frac, out_index};
    assign m_tuser = {out_case, out_matched};

endmodule
